[src/lqie_pkg.sv]
// Shared widths, constants and types for the log-domain quartic interpolator.
`timescale 1ns / 1ps
`default_nettype none
package lqie_pkg;

  localparam int BANDS_DEF = 64;
  localparam int GRID      = 5;
  localparam int SMP_W     = 32;
  localparam int F_W       = 17;
  localparam int COEF_W    = 42;
  localparam int U_W       = 42;
  localparam int N_W       = 7;
  localparam int VAL_W     = 48;

  localparam logic [F_W-1:0] F_ONE = 17'd65536;

  // result range limits, in units of 2^-20 / 36
  localparam logic signed [COEF_W-1:0] T_HI = 42'sd452984832;
  localparam logic signed [COEF_W-1:0] T_LO = -42'sd905969664;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  // floor(u / 9) == (u * DIV9_M) >> 45 for u < 2^42
  localparam int          DIV9_SH = 45;
  localparam logic [47:0] DIV9_M  = ((48'd1 << DIV9_SH) + 48'd8) / 48'd9;
  localparam logic [20:0] DIV9_MH = DIV9_M[41:21];
  localparam logic [20:0] DIV9_ML = DIV9_M[20:0];

  // 96 * log2(e) in Q30: removes the offset that keeps the product positive
  localparam logic signed [39:0] YQ_BIAS = 40'sd148711872480;

  localparam logic signed [N_W-1:0] N_SAT = 7'sd16;

  typedef logic signed [COEF_W-1:0] coef_t;

  // exp series pipeline word
  typedef struct packed {
    logic                  vld;
    logic                  sat;
    logic signed [N_W-1:0] n;
    logic [31:0]           w;
    logic [33:0]           m;
    logic [31:0]           term;
  } ser_t;

endpackage
`default_nettype wire

[src/lqie_lerp.sv]
// One registered de Casteljau blend: p + round((q - p) * f / 65536).
`timescale 1ns / 1ps
`default_nettype none
module lqie_lerp
  import lqie_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           en,
  input  wire coef_t          p,
  input  wire coef_t          q,
  input  wire logic [F_W-1:0] f,
  output coef_t               res
);

  logic signed [COEF_W:0]        diff;
  logic signed [COEF_W+F_W+1:0]  prod;
  logic signed [COEF_W+F_W+1:0]  rnd;
  coef_t                         res_nxt;
  coef_t                         res_r;

  always_comb begin
    diff    = (COEF_W+1)'(q) - (COEF_W+1)'(p);
    prod    = diff * $signed({1'b0, f});
    rnd     = (prod + (COEF_W+F_W+2)'(32768)) >>> 16;
    res_nxt = p + $signed(rnd[COEF_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

[src/lqie_term.sv]
// One exp series term: term_i = ((term * w) >> 32) / I over two stages.
`timescale 1ns / 1ps
`default_nettype none
module lqie_term
  import lqie_pkg::*;
#(
  parameter int I = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire ser_t d,
  output ser_t      q
);

  localparam int          K     = 32 + $clog2(I);
  localparam logic [33:0] RECIP = 34'(((66'd1 << K) + 66'(I) - 66'd1) / 66'(I));

  logic [63:0] prod_a;
  logic [67:0] prod_b;
  ser_t        a_nxt;
  ser_t        a_r;
  ser_t        b_nxt;
  ser_t        b_r;

  always_comb begin
    prod_a     = 64'(d.term) * 64'(d.w);
    a_nxt      = d;
    a_nxt.term = prod_a[63:32];
    a_nxt.m    = d.m + 34'(d.term);
  end

  always_comb begin
    // reciprocal multiply: exact floor division for 32-bit dividends
    prod_b     = 68'(a_r.term) * 68'(RECIP);
    b_nxt      = a_r;
    b_nxt.term = prod_b[K+31:K];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
      b_r.vld <= 1'b0;
    end else if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign q = b_r;

endmodule
`default_nettype wire

[src/log_quartic_interp_exp.sv]
// Top level: sample store, quartic Bernstein interpolation and exp pipeline.
//
// Input words (in_*): in_tuser = 0 writes one sample of a band at a grid
// point (0..4); in_tuser = 1 evaluates a band at fraction f (Q1.16, values
// above one are clamped to one). Writes give no output word; an evaluate of
// a band below BANDS gives one output word, others give none.
// Output words (out_*): exp of the interpolated log value, unsigned Q16.32,
// with out_tuser set when the value was clamped to all ones.
// Throughput: one word per cycle while out_tready does not stall the output;
// every stage is a register stage with its own valid bit, five per-grid-point
// sample memories are read in the same cycle, and the exp series takes two
// stages per term (multiply, then reciprocal divide).
// A sample written in one cycle is seen by an evaluate in the next cycle.
// When out_tready is low with a word waiting, the whole pipeline holds and
// in_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; sample memories are not cleared and must be
// written before a band is evaluated.
`timescale 1ns / 1ps
`default_nettype none
module log_quartic_interp_exp
  import lqie_pkg::*;
#(
  parameter int BANDS = BANDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // band[5:0], grid_point[8:6], sample[40:9],
                                      // fraction[57:41], zero fill
  input  wire logic        in_tuser,  // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata, // value
  output logic             out_tuser  // saturated
);

  localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;

  logic                    adv;
  logic                    acc;
  logic [5:0]              in_band;
  logic [2:0]              in_grid;
  logic [SMP_W-1:0]        in_sample;
  logic [F_W-1:0]          in_frac;
  logic                    band_ok;
  logic [AW-1:0]           addr;
  logic [F_W-1:0]          f_clamp;

  logic [10:1]             vld_r;
  logic [F_W-1:0]          f_r [1:5];
  logic signed [SMP_W-1:0] y_r [GRID];
  coef_t                   ye [GRID];
  coef_t                   coef_nxt [GRID];
  coef_t                   coef_r [GRID];
  coef_t                   tri_w [15];

  logic                    sat7_nxt;
  coef_t                   tc;
  coef_t                   tp_full;
  logic [30:0]             tp_r;
  logic                    sat7_r;
  logic [61:0]             z8;
  logic [U_W-1:0]          u_r;
  logic                    sat8_r;
  logic [62:0]             ph_r;
  logic [62:0]             pl_r;
  logic                    sat9_r;
  logic [83:0]             qsum;
  logic signed [39:0]      yq;
  logic signed [N_W-1:0]   n10_nxt;
  logic signed [N_W-1:0]   n10_r;
  logic [31:0]             r10_r;
  logic                    sat10_r;
  logic [63:0]             wprod;
  ser_t                    s11_nxt;
  ser_t                    s11_r;
  ser_t                    ser_w [13];

  logic                    mf_vld_r;
  logic                    mf_sat_r;
  logic signed [N_W-1:0]   mf_n_r;
  logic [33:0]             mf_m_r;

  logic [49:0]             shl;
  logic [49:0]             shr;
  logic [49:0]             val;
  logic [5:0]              sh_s;
  logic                    sat_o;
  logic [VAL_W-1:0]        out_tdata_nxt;
  logic                    out_vld_r;
  logic [VAL_W-1:0]        out_tdata_r;
  logic                    out_tuser_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  assign in_band   = in_tdata[5:0];
  assign in_grid   = in_tdata[8:6];
  assign in_sample = in_tdata[40:9];
  assign in_frac   = in_tdata[57:41];
  assign band_ok   = (32'(in_band) < BANDS);
  assign addr      = AW'(in_band);
  assign f_clamp   = (in_frac > F_ONE) ? F_ONE : in_frac;

  // sample memories, one per grid point, read data registered
  for (genvar g = 0; g < GRID; g++) begin : g_mem
    logic [SMP_W-1:0] mem [BANDS];
    always_ff @(posedge clk) begin
      if (acc && !in_tuser && band_ok && (in_grid == 3'(g))) begin
        mem[addr] <= in_sample;
      end
      if (adv) begin
        y_r[g] <= $signed(mem[addr]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[9:1], acc && in_tuser && band_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r[1] <= f_clamp;
      for (int k = 2; k <= 5; k++) begin
        f_r[k] <= f_r[k-1];
      end
    end
  end

  // Bernstein coefficients, scaled by 36
  always_comb begin
    for (int i = 0; i < GRID; i++) begin
      ye[i] = COEF_W'(y_r[i]);
    end
    coef_nxt[0] = ye[0] * 42'sd36;
    coef_nxt[4] = ye[4] * 42'sd36;
    coef_nxt[1] = 42'sd3 * (ye[1] * 42'sd48 + ye[3] * 42'sd16
                            - ye[0] * 42'sd13 - ye[2] * 42'sd36 - ye[4] * 42'sd3);
    coef_nxt[3] = 42'sd3 * (ye[3] * 42'sd48 + ye[1] * 42'sd16
                            - ye[4] * 42'sd13 - ye[2] * 42'sd36 - ye[0] * 42'sd3);
    coef_nxt[2] = 42'sd2 * ((ye[0] + ye[4]) * 42'sd13 - (ye[1] + ye[3]) * 42'sd64
                            + ye[2] * 42'sd120);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < GRID; i++) begin
        coef_r[i] <= coef_nxt[i];
      end
    end
  end

  for (genvar i = 0; i < GRID; i++) begin : g_tri0
    assign tri_w[i] = coef_r[i];
  end

  // de Casteljau levels, one register stage each
  for (genvar k = 1; k < GRID; k++) begin : g_lvl
    localparam int OP = 5 * (k - 1) - ((k - 1) * (k - 2)) / 2;
    localparam int OC = 5 * k - (k * (k - 1)) / 2;
    for (genvar i = 0; i < GRID - k; i++) begin : g_pt
      lqie_lerp u_lerp (
        .clk (clk),
        .en  (adv),
        .p   (tri_w[OP+i]),
        .q   (tri_w[OP+i+1]),
        .f   (f_r[k+1]),
        .res (tri_w[OC+i])
      );
    end
  end

  // clamp and offset so the log2(e) product stays positive
  always_comb begin
    sat7_nxt = tri_w[14] > T_HI;
    tc       = (tri_w[14] < T_LO) ? T_LO : tri_w[14];
    tp_full  = tc - T_LO;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tp_r   <= tp_full[30:0];
      sat7_r <= sat7_nxt;
    end
  end

  assign z8 = 62'(tp_r) * 62'(LOG2E_Q30);

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r    <= z8[61:20];
      sat8_r <= sat7_r;
      ph_r   <= 63'(u_r) * 63'(DIV9_MH);
      pl_r   <= 63'(u_r) * 63'(DIV9_ML);
      sat9_r <= sat8_r;
    end
  end

  always_comb begin
    qsum    = {ph_r, 21'd0} + 84'(pl_r);
    yq      = $signed(40'(qsum >> DIV9_SH)) - YQ_BIAS;
    n10_nxt = yq[38:32];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n10_r   <= n10_nxt;
      r10_r   <= yq[31:0];
      sat10_r <= sat9_r || (n10_nxt >= N_SAT);
    end
  end

  always_comb begin
    wprod        = 64'(r10_r) * 64'(LN2_Q32);
    s11_nxt.vld  = vld_r[10];
    s11_nxt.sat  = sat10_r;
    s11_nxt.n    = n10_r;
    s11_nxt.w    = wprod[63:32];
    s11_nxt.m    = 34'h1_0000_0000;
    s11_nxt.term = wprod[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_r.vld <= 1'b0;
    end else if (adv) begin
      s11_r <= s11_nxt;
    end
  end

  assign ser_w[0] = s11_r;

  for (genvar j = 1; j <= 12; j++) begin : g_term
    lqie_term #(.I(j + 1)) u_term (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d     (ser_w[j-1]),
      .q     (ser_w[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mf_vld_r <= 1'b0;
    end else if (adv) begin
      mf_vld_r <= ser_w[12].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mf_sat_r <= ser_w[12].sat;
      mf_n_r   <= ser_w[12].n;
      mf_m_r   <= ser_w[12].m + 34'(ser_w[12].term);
    end
  end

  // scale by 2^n, rounding on right shifts
  always_comb begin
    shl           = 50'(mf_m_r) << mf_n_r[3:0];
    sh_s          = 6'(-mf_n_r);
    shr           = (50'(mf_m_r) + (50'd1 << (sh_s - 6'd1))) >> sh_s;
    val           = mf_n_r[N_W-1] ? shr : shl;
    sat_o         = mf_sat_r || (val[49:48] != 2'b00);
    out_tdata_nxt = sat_o ? '1 : val[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= mf_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= sat_o;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef ASSERT_OFF
  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '1))
    else $error("saturated word without all-ones value");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> !vld_r[1])
    else $error("write word entered the evaluate pipeline");

  a_series_floor: assert property (@(posedge clk) disable iff (!rst_n)
    mf_vld_r |-> (mf_m_r[33:32] != 2'b00))
    else $error("exp mantissa below one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> ($stable(out_tdata) && $stable(vld_r)))
    else $error("pipeline moved during output stall");
`endif

endmodule
`default_nettype wire

[verif/log_quartic_interp_exp_checker.sv]
// Checker for the log-domain quartic interpolator: shadow sample store, predictor, compare.
`timescale 1ns / 1ps
module log_quartic_interp_exp_checker
  import lqie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          sat_seen
);

  localparam longint TSC = 36 * 1048576;

  typedef struct packed {
    logic [47:0] value;
    logic        sat;
  } exp_word_t;

  logic signed [31:0] shadow_store [BANDS_DEF*GRID];
  exp_word_t          exp_q [$];

  function automatic longint fdiv(longint x, longint d);
    longint q;
    q = x / d;
    if ((x % d) != 0 && x < 0) q--;
    return q;
  endfunction

  function automatic exp_word_t predict_exp(logic [5:0] band, logic [16:0] fr);
    longint y [GRID];
    longint a [GRID];
    longint f, t, yq, n;
    logic [63:0] r, w, term, m, value;
    exp_word_t res;
    for (int i = 0; i < GRID; i++) y[i] = shadow_store[band*GRID + i];
    a[0] = 36 * y[0];
    a[4] = 36 * y[4];
    a[1] = 3 * (-13*y[0] + 48*y[1] - 36*y[2] + 16*y[3] - 3*y[4]);
    a[3] = 3 * (-13*y[4] + 48*y[3] - 36*y[2] + 16*y[1] - 3*y[0]);
    a[2] = 2 * (13*(y[0]+y[4]) - 64*(y[1]+y[3]) + 120*y[2]);
    f = (fr > 17'd65536) ? 65536 : longint'(fr);
    for (int lvl = GRID-1; lvl > 0; lvl--)
      for (int i = 0; i < lvl; i++)
        a[i] = fdiv(a[i]*(65536-f) + a[i+1]*f + 32768, 65536);
    t = a[0];
    res.value = '1;
    res.sat = 1'b1;
    if (t > 12*TSC) return res;
    if (t < -24*TSC) t = -24*TSC;
    yq = fdiv(t * 64'sd1549082005, 9*1048576);
    n = fdiv(yq, 64'sd4294967296);
    r = yq - n * 64'sd4294967296;
    if (n >= 16) return res;
    w = (r * 64'd2977044472) >> 32;
    term = 64'd1 << 32;
    m = term;
    for (int i = 1; i <= 13; i++) begin
      term = ((term * w) >> 32) / i;
      m += term;
    end
    if (n >= 0) value = m << n;
    else value = (m + (64'd1 << (-n-1))) >> (-n);
    if (value > 64'hFFFF_FFFF_FFFF) return res;
    res.value = value[47:0];
    res.sat = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
    sat_seen = 0;
  end

  always @(posedge clk) begin
    exp_word_t e;
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == 1'b0) begin
        if (in_tdata[8:6] < GRID)
          shadow_store[in_tdata[5:0]*GRID + in_tdata[8:6]] <= in_tdata[40:9];
      end else begin
        exp_q.push_back(predict_exp(in_tdata[5:0], in_tdata[57:41]));
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser) sat_seen++;
      if (exp_q.size() == 0) report_mismatch("output word with nothing expected");
      else begin
        e = exp_q.pop_front();
        if (out_tdata !== e.value)
          report_mismatch($sformatf("value %h, expected %h", out_tdata, e.value));
        if (out_tuser !== e.sat)
          report_mismatch($sformatf("saturated %b, expected %b", out_tuser, e.sat));
      end
    end
    pending = exp_q.size();
  end

endmodule

[verif/log_quartic_interp_exp_test.sv]
// Testbench top for the log-domain quartic interpolator: stimulus and verdict.
`timescale 1ns / 1ps
module log_quartic_interp_exp_test;
  import lqie_pkg::*;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  int          fail_count, pending, results_seen, sat_seen;
  bit          written [BANDS_DEF];
  bit          no_gaps;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  log_quartic_interp_exp dut (.*);

  log_quartic_interp_exp_checker chk (.*);

  // tvalid stays high between back-to-back words; dropped only for a gap
  task automatic send_word(logic op, logic [5:0] band, logic [2:0] gp,
                           logic [31:0] smp, logic [16:0] fr);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, fr, smp, gp, band};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic fill_band(logic [5:0] band, bit big);
    logic [31:0] s;
    for (int g = 0; g < GRID; g++) begin
      s = big ? $urandom() : 32'($signed($urandom_range(0, 8000000)) - 4000000);
      send_word(OP_WRITE, band, 3'(g), s, 17'($urandom()));
    end
    written[band] = 1'b1;
  endtask

  function automatic logic [16:0] rand_fraction();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom()) | 17'h10000;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [5:0] written_band();
    logic [5:0] b;
    do b = 6'($urandom()); while (!written[b]);
    return b;
  endfunction

  // random receiver stalls on out_tready
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (no_gaps) out_tready <= 1'b1;
      else begin
        stall = $urandom_range(0, 17);
        if (stall == 0 || $urandom_range(0, 3) == 0) out_tready <= 1'b1;
        else begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int k;
    no_gaps = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme samples, ignored writes, fraction ends
    for (int g = 0; g < GRID; g++)
      send_word(OP_WRITE, 6'd0, 3'(g), 32'h8000_0000, 17'd0);
    written[0] = 1'b1;
    send_word(OP_EVAL, 6'd0, 3'd7, 32'hFFFF_FFFF, 17'd0);
    for (int g = 0; g < GRID; g++)
      send_word(OP_WRITE, 6'd63, 3'(g), 32'h7FFF_FFFF, 17'h1FFFF);
    written[63] = 1'b1;
    send_word(OP_EVAL, 6'd63, 3'd0, 32'd0, 17'd65536);
    send_word(OP_WRITE, 6'd63, 3'd5, 32'h0, 17'd0);
    send_word(OP_WRITE, 6'd63, 3'd7, 32'h1234, 17'd0);
    send_word(OP_EVAL, 6'd63, 3'd0, 32'd0, 17'h1FFFF);
    send_word(OP_WRITE, 6'd63, 3'd2, 32'h0000_0000, 17'd0);
    send_word(OP_EVAL, 6'd63, 3'd0, 32'd0, 17'd32768);
    send_word(OP_EVAL, 6'd0, 3'd0, 32'd0, 17'd1);
    send_word(OP_EVAL, 6'd0, 3'd0, 32'd0, 17'd65535);

    // random: mostly fill-then-evaluate with modest samples, a few wild ones
    k = 0;
    while (k < 1620) begin
      no_gaps = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          fill_band(6'($urandom()), $urandom_range(0, 4) == 0);
          k += GRID;
        end
        2: begin
          send_word(OP_WRITE, 6'($urandom()), 3'($urandom_range(5, 7)),
                    $urandom(), 17'($urandom()));
        end
        default: begin
          send_word(OP_EVAL, written_band(), 3'($urandom()), $urandom(),
                    rand_fraction());
          k++;
        end
      endcase
    end
    in_tvalid <= 1'b0;
    no_gaps = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d result words, %0d saturated, random gaps and stalls.",
             results_seen, sat_seen);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
